// ===== src/qmn_pkg.sv =====
// shared constants, term tables and types for the normalized quaternion product
`timescale 1ns / 1ps
package qmn_pkg;

    localparam int DATA_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 30;

    // common mantissa after block scaling, squared sum and root widths
    localparam int MANT_BITS = 30;
    localparam int SUM_BITS  = 2 * MANT_BITS + 2;
    localparam int ROOT_BITS = MANT_BITS + 1;

    // hamilton product terms: four per output lane, a index, b index, subtract flag
    localparam logic [1:0] TERM_A [16] = '{
        2'd0, 2'd1, 2'd2, 2'd3,
        2'd0, 2'd1, 2'd2, 2'd3,
        2'd0, 2'd2, 2'd3, 2'd1,
        2'd0, 2'd3, 2'd1, 2'd2
    };
    localparam logic [1:0] TERM_B [16] = '{
        2'd0, 2'd1, 2'd2, 2'd3,
        2'd1, 2'd0, 2'd3, 2'd2,
        2'd2, 2'd0, 2'd1, 2'd3,
        2'd3, 2'd0, 2'd2, 2'd1
    };
    localparam logic TERM_SUB [16] = '{
        1'b0, 1'b1, 1'b1, 1'b1,
        1'b0, 1'b0, 1'b0, 1'b1,
        1'b0, 1'b0, 1'b0, 1'b1,
        1'b0, 1'b0, 1'b0, 1'b1
    };

    // per word side information that rides along the pipeline
    typedef struct packed {
        logic       degen;
        logic [3:0] neg;
    } t_meta;

endpackage

// ===== src/qmn_product.sv =====
// exact hamilton product: partial products, then four-term sums
`timescale 1ns / 1ps
module qmn_product #(
    parameter int DATA_WIDTH = qmn_pkg::DATA_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  logic [DATA_WIDTH-1:0]         i_a [4],
    input  logic [DATA_WIDTH-1:0]         i_b [4],
    output logic                          o_valid,
    output logic signed [2*DATA_WIDTH+1:0] o_p [4]
);
    import qmn_pkg::*;

    localparam int PROD_W = 2 * DATA_WIDTH;
    localparam int PW     = 2 * DATA_WIDTH + 2;

    logic signed [PROD_W-1:0] n_prod [16];
    logic signed [PROD_W-1:0] r_prod [16];
    logic signed [PW-1:0]     n_sum [4];
    logic signed [PW-1:0]     r_sum [4];
    logic                     r_valid1;
    logic                     r_valid2;

    // signed partial products with the sign of each term applied
    always_comb begin
        for (int t = 0; t < 16; t++) begin
            n_prod[t] = $signed(i_a[TERM_A[t]]) * $signed(i_b[TERM_B[t]]);
            if (TERM_SUB[t]) begin
                n_prod[t] = -n_prod[t];
            end
        end
    end

    // four-term sum per lane
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            n_sum[i] = PW'(r_prod[4*i]) + PW'(r_prod[4*i+1])
                     + PW'(r_prod[4*i+2]) + PW'(r_prod[4*i+3]);
        end
    end

    // stage registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid1 <= 1'b0;
            r_valid2 <= 1'b0;
        end else if (i_en) begin
            r_valid1 <= i_valid;
            r_valid2 <= r_valid1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= n_prod;
            r_sum  <= n_sum;
        end
    end

    assign o_valid = r_valid2;
    assign o_p     = r_sum;

endmodule

// ===== src/qmn_scale.sv =====
// block scaling to a common mantissa, then sum of squares
`timescale 1ns / 1ps
module qmn_scale #(
    parameter int DATA_WIDTH = qmn_pkg::DATA_WIDTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_en,
    input  logic                            i_valid,
    input  logic signed [2*DATA_WIDTH+1:0]  i_p [4],
    output logic                            o_valid,
    output logic [qmn_pkg::MANT_BITS-1:0]   o_c [4],
    output logic [qmn_pkg::SUM_BITS-1:0]    o_s,
    output qmn_pkg::t_meta                  o_meta
);
    import qmn_pkg::*;

    localparam int PW = 2 * DATA_WIDTH + 2;
    localparam int MW = PW - 1;
    localparam int LW = $clog2(MW + 1);
    localparam int NW = MW + MANT_BITS;

    logic [MW-1:0]          n3_mag [4];
    logic [3:0]             n3_neg;
    logic [MW-1:0]          n3_or;
    logic [LW-1:0]          n3_lmax;
    logic [MW-1:0]          r3_mag [4];
    logic [3:0]             r3_neg;
    logic [LW-1:0]          r3_lmax;
    logic [MANT_BITS-1:0]   n4_c [4];
    logic [MANT_BITS-1:0]   r4_c [4];
    t_meta                  r4_meta;
    logic [2*MANT_BITS-1:0] r5_sq [4];
    logic [MANT_BITS-1:0]   r5_c [4];
    t_meta                  r5_meta;
    logic [SUM_BITS-1:0]    r6_s;
    logic [MANT_BITS-1:0]   r6_c [4];
    t_meta                  r6_meta;
    logic [3:0]             r_valid;

    // magnitudes, signs and bit length of the largest
    always_comb begin
        n3_or   = '0;
        n3_lmax = '0;
        for (int i = 0; i < 4; i++) begin
            n3_neg[i] = i_p[i][PW-1];
            n3_mag[i] = n3_neg[i] ? MW'(-i_p[i]) : MW'(i_p[i]);
            n3_or     = n3_or | n3_mag[i];
        end
        for (int b = 0; b < MW; b++) begin
            if (n3_or[b]) begin
                n3_lmax = LW'(b + 1);
            end
        end
    end

    // shift every lane so the largest lands on the mantissa top bit
    always_comb begin
        logic [NW-1:0] w_shift;
        for (int i = 0; i < 4; i++) begin
            w_shift = {r3_mag[i], {MANT_BITS{1'b0}}} >> r3_lmax;
            n4_c[i] = w_shift[MANT_BITS-1:0];
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_en) begin
            r_valid <= {r_valid[2:0], i_valid};
        end
    end

    // payload stages
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_mag        <= n3_mag;
            r3_neg        <= n3_neg;
            r3_lmax       <= n3_lmax;
            r4_c          <= n4_c;
            r4_meta.neg   <= r3_neg;
            r4_meta.degen <= (r3_lmax == '0);
            for (int i = 0; i < 4; i++) begin
                r5_sq[i] <= r4_c[i] * r4_c[i];
            end
            r5_c    <= r4_c;
            r5_meta <= r4_meta;
            r6_s    <= SUM_BITS'(r5_sq[0]) + SUM_BITS'(r5_sq[1])
                     + SUM_BITS'(r5_sq[2]) + SUM_BITS'(r5_sq[3]);
            r6_c    <= r5_c;
            r6_meta <= r5_meta;
        end
    end

    assign o_valid = r_valid[3];
    assign o_c     = r6_c;
    assign o_s     = r6_s;
    assign o_meta  = r6_meta;

endmodule

// ===== src/qmn_isqrt.sv =====
// integer square root, one result bit per pipeline stage
`timescale 1ns / 1ps
module qmn_isqrt (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  logic [qmn_pkg::SUM_BITS-1:0]  i_s,
    input  logic [qmn_pkg::MANT_BITS-1:0] i_c [4],
    input  qmn_pkg::t_meta                i_meta,
    output logic                          o_valid,
    output logic [qmn_pkg::ROOT_BITS-1:0] o_len,
    output logic [qmn_pkg::MANT_BITS-1:0] o_c [4],
    output qmn_pkg::t_meta                o_meta
);
    import qmn_pkg::*;

    localparam int SW = SUM_BITS;

    logic [SW-1:0]        r_rem [ROOT_BITS];
    logic [SW-1:0]        r_res [ROOT_BITS];
    logic [MANT_BITS-1:0] r_c [ROOT_BITS][4];
    t_meta                r_meta [ROOT_BITS];
    logic [ROOT_BITS-1:0] r_valid;

    for (genvar k = 0; k < ROOT_BITS; k++) begin : g_stage
        localparam logic [SW:0] BIT = {{SW{1'b0}}, 1'b1} << (2 * (ROOT_BITS - 1 - k));

        logic [SW-1:0]        w_rem;
        logic [SW-1:0]        w_res;
        logic [MANT_BITS-1:0] w_c [4];
        t_meta                w_meta;
        logic                 w_valid;
        logic [SW:0]          w_trial;
        logic                 w_ge;

        // stage input
        if (k == 0) begin : g_first
            assign w_rem   = i_s;
            assign w_res   = '0;
            assign w_c     = i_c;
            assign w_meta  = i_meta;
            assign w_valid = i_valid;
        end else begin : g_next
            assign w_rem   = r_rem[k-1];
            assign w_res   = r_res[k-1];
            assign w_c     = r_c[k-1];
            assign w_meta  = r_meta[k-1];
            assign w_valid = r_valid[k-1];
        end

        // trial subtract for this root bit
        assign w_trial = {1'b0, w_res} + BIT;
        assign w_ge    = ({1'b0, w_rem} >= w_trial);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[k] <= 1'b0;
            end else if (i_en) begin
                r_valid[k] <= w_valid;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (w_ge) begin
                    r_rem[k] <= SW'({1'b0, w_rem} - w_trial);
                    r_res[k] <= SW'(({1'b0, w_res} >> 1) + BIT);
                end else begin
                    r_rem[k] <= w_rem;
                    r_res[k] <= w_res >> 1;
                end
                r_c[k]    <= w_c;
                r_meta[k] <= w_meta;
            end
        end
    end

    assign o_valid = r_valid[ROOT_BITS-1];
    assign o_len   = r_res[ROOT_BITS-1][ROOT_BITS-1:0];
    assign o_c     = r_c[ROOT_BITS-1];
    assign o_meta  = r_meta[ROOT_BITS-1];

endmodule

// ===== src/qmn_divide.sv =====
// restoring fractional divide, one quotient bit per stage, then saturation
`timescale 1ns / 1ps
module qmn_divide #(
    parameter int DATA_WIDTH = qmn_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = qmn_pkg::FRAC_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  logic [qmn_pkg::ROOT_BITS-1:0] i_len,
    input  logic [qmn_pkg::MANT_BITS-1:0] i_c [4],
    input  qmn_pkg::t_meta                i_meta,
    output logic                          o_valid,
    output logic [DATA_WIDTH-1:0]         o_r [4],
    output logic                          o_degen
);
    import qmn_pkg::*;

    localparam int QW = FRAC_BITS + 1;
    localparam int RW = ROOT_BITS + 1;
    localparam int CW = ((QW > DATA_WIDTH) ? QW : DATA_WIDTH) + 1;
    localparam logic [CW-1:0] MAX_POS = {1'b0, {(CW-1){1'b1}}} >> (CW - DATA_WIDTH);
    localparam logic [CW-1:0] MAX_NEG = MAX_POS + 1'b1;

    logic [RW-1:0]         r_rem [QW][4];
    logic [QW-1:0]         r_q [QW][4];
    logic [ROOT_BITS-1:0]  r_den [QW];
    t_meta                 r_meta [QW];
    logic [QW-1:0]         r_valid;
    logic [DATA_WIDTH-1:0] n_out [4];
    logic [DATA_WIDTH-1:0] r_out [4];
    logic                  r_degen;
    logic                  r_out_valid;

    for (genvar j = 0; j < QW; j++) begin : g_stage
        logic [RW-1:0]        w_rin [4];
        logic [QW-1:0]        w_q [4];
        logic [ROOT_BITS-1:0] w_den;
        t_meta                w_meta;
        logic                 w_valid;

        // stage input: fresh numerator, or shifted partial remainder
        if (j == 0) begin : g_first
            for (genvar i = 0; i < 4; i++) begin : g_lane
                assign w_rin[i] = RW'(i_c[i]);
                assign w_q[i]   = '0;
            end
            assign w_den   = i_len;
            assign w_meta  = i_meta;
            assign w_valid = i_valid;
        end else begin : g_next
            for (genvar i = 0; i < 4; i++) begin : g_lane
                assign w_rin[i] = {r_rem[j-1][i][RW-2:0], 1'b0};
                assign w_q[i]   = r_q[j-1][i];
            end
            assign w_den   = r_den[j-1];
            assign w_meta  = r_meta[j-1];
            assign w_valid = r_valid[j-1];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[j] <= 1'b0;
            end else if (i_en) begin
                r_valid[j] <= w_valid;
            end
        end

        // compare and subtract on all four lanes
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                for (int i = 0; i < 4; i++) begin
                    if (w_rin[i] >= RW'(w_den)) begin
                        r_rem[j][i] <= w_rin[i] - RW'(w_den);
                        r_q[j][i]   <= {w_q[i][QW-2:0], 1'b1};
                    end else begin
                        r_rem[j][i] <= w_rin[i];
                        r_q[j][i]   <= {w_q[i][QW-2:0], 1'b0};
                    end
                end
                r_den[j]  <= w_den;
                r_meta[j] <= w_meta;
            end
        end
    end

    // clamp to the signed range and apply the sign; a degenerate word gives all zeros
    always_comb begin
        logic [CW-1:0] w_q;
        logic [CW-1:0] w_sat;
        logic [CW-1:0] w_neg;
        for (int i = 0; i < 4; i++) begin
            w_q = CW'(r_q[QW-1][i]);
            if (r_meta[QW-1].neg[i]) begin
                w_sat = (w_q > MAX_NEG) ? MAX_NEG : w_q;
            end else begin
                w_sat = (w_q > MAX_POS) ? MAX_POS : w_q;
            end
            w_neg = '0 - w_sat;
            if (r_meta[QW-1].degen) begin
                n_out[i] = '0;
            end else if (r_meta[QW-1].neg[i]) begin
                n_out[i] = w_neg[DATA_WIDTH-1:0];
            end else begin
                n_out[i] = w_sat[DATA_WIDTH-1:0];
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_en) begin
            r_out_valid <= r_valid[QW-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_out   <= n_out;
            r_degen <= r_meta[QW-1].degen;
        end
    end

    assign o_valid = r_out_valid;
    assign o_r     = r_out;
    assign o_degen = r_degen;

endmodule

// ===== src/quaternion_multiply_normalize.sv =====
// throughput: one word per cycle while the output is not stalled
// the square root takes 31 stages, the divide FRAC_BITS + 1
// a stalled output word freezes every stage, nothing is dropped or repeated
// o_ready is high whenever the output register is empty or being taken
// reset (synchronous, active low) clears all valid bits; no clearing pass
`timescale 1ns / 1ps
module quaternion_multiply_normalize #(
    parameter int DATA_WIDTH = qmn_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = qmn_pkg::FRAC_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [DATA_WIDTH-1:0] i_a_w,
    input  logic [DATA_WIDTH-1:0] i_a_x,
    input  logic [DATA_WIDTH-1:0] i_a_y,
    input  logic [DATA_WIDTH-1:0] i_a_z,
    input  logic [DATA_WIDTH-1:0] i_b_w,
    input  logic [DATA_WIDTH-1:0] i_b_x,
    input  logic [DATA_WIDTH-1:0] i_b_y,
    input  logic [DATA_WIDTH-1:0] i_b_z,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [DATA_WIDTH-1:0] o_r_w,
    output logic [DATA_WIDTH-1:0] o_r_x,
    output logic [DATA_WIDTH-1:0] o_r_y,
    output logic [DATA_WIDTH-1:0] o_r_z,
    output logic                  o_degenerate
);
    import qmn_pkg::*;

    logic                         w_en;
    logic [DATA_WIDTH-1:0]        w_a [4];
    logic [DATA_WIDTH-1:0]        w_b [4];
    logic                         w_p_valid;
    logic signed [2*DATA_WIDTH+1:0] w_p [4];
    logic                         w_s_valid;
    logic [MANT_BITS-1:0]         w_s_c [4];
    logic [SUM_BITS-1:0]          w_s;
    t_meta                        w_s_meta;
    logic                         w_r_valid;
    logic [ROOT_BITS-1:0]         w_len;
    logic [MANT_BITS-1:0]         w_r_c [4];
    t_meta                        w_r_meta;
    logic [DATA_WIDTH-1:0]        w_out [4];

    // whole pipeline advances unless a finished word is held
    assign w_en    = !o_valid || i_ready;
    assign o_ready = w_en;

    assign w_a[0] = i_a_w;
    assign w_a[1] = i_a_x;
    assign w_a[2] = i_a_y;
    assign w_a[3] = i_a_z;
    assign w_b[0] = i_b_w;
    assign w_b[1] = i_b_x;
    assign w_b[2] = i_b_y;
    assign w_b[3] = i_b_z;

    qmn_product #(.DATA_WIDTH(DATA_WIDTH)) u_product (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_valid),
        .i_a     (w_a),
        .i_b     (w_b),
        .o_valid (w_p_valid),
        .o_p     (w_p)
    );

    qmn_scale #(.DATA_WIDTH(DATA_WIDTH)) u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_p_valid),
        .i_p     (w_p),
        .o_valid (w_s_valid),
        .o_c     (w_s_c),
        .o_s     (w_s),
        .o_meta  (w_s_meta)
    );

    qmn_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_s_valid),
        .i_s     (w_s),
        .i_c     (w_s_c),
        .i_meta  (w_s_meta),
        .o_valid (w_r_valid),
        .o_len   (w_len),
        .o_c     (w_r_c),
        .o_meta  (w_r_meta)
    );

    qmn_divide #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS)) u_divide (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_r_valid),
        .i_len   (w_len),
        .i_c     (w_r_c),
        .i_meta  (w_r_meta),
        .o_valid (o_valid),
        .o_r     (w_out),
        .o_degen (o_degenerate)
    );

    assign o_r_w = w_out[0];
    assign o_r_x = w_out[1];
    assign o_r_y = w_out[2];
    assign o_r_z = w_out[3];

endmodule

// ===== src/qmn_checker.sv =====
// port-level checks for the normalized quaternion product, bound to the top level
`timescale 1ns / 1ps
module qmn_checker #(
    parameter int DATA_WIDTH = qmn_pkg::DATA_WIDTH_DEF
) (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  o_ready,
    input logic                  o_valid,
    input logic                  i_ready,
    input logic [DATA_WIDTH-1:0] o_r_w,
    input logic [DATA_WIDTH-1:0] o_r_x,
    input logic [DATA_WIDTH-1:0] o_r_y,
    input logic [DATA_WIDTH-1:0] o_r_z,
    input logic                  o_degenerate
);

    // a degenerate word carries all-zero components
    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_degenerate |-> (o_r_w == '0) && (o_r_x == '0)
                                    && (o_r_y == '0) && (o_r_z == '0))
        else $error("degenerate word with nonzero components");

    // a held output word blocks the input side
    a_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |-> !o_ready)
        else $error("input accepted while output stalled");

    // an empty output register always admits a word
    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("input refused with empty output");

    // stalled output word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_r_w) && $stable(o_r_x)
                                && $stable(o_r_y) && $stable(o_r_z)
                                && $stable(o_degenerate))
        else $error("output word changed while stalled");

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid right after reset");

endmodule

bind quaternion_multiply_normalize qmn_checker #(.DATA_WIDTH(DATA_WIDTH)) u_qmn_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_ready      (o_ready),
    .o_valid      (o_valid),
    .i_ready      (i_ready),
    .o_r_w        (o_r_w),
    .o_r_x        (o_r_x),
    .o_r_y        (o_r_y),
    .o_r_z        (o_r_z),
    .o_degenerate (o_degenerate)
);
